### rtl/core/tsmd_pkg.sv
package tsmd_pkg;

    localparam int FIELD_BITS     = 64;
    localparam int DEF_KEY_BITS   = 64;
    localparam int DEF_VALUE_BITS = 64;
    localparam int DATA_BITS      = 3 * FIELD_BITS;
    localparam int OUT_USER_BITS  = 3;
    localparam int CFG_IDX_BITS   = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_VISIBLE_LIMIT = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KEEP_VERSIONS = 1'd1;

    // Stream codes
    localparam logic SRC_A = 1'b0;
    localparam logic SRC_B = 1'b1;

    typedef struct packed {
        logic                  src;
        logic                  last;
        logic                  vis;
        logic [FIELD_BITS-1:0] key;
        logic [FIELD_BITS-1:0] val;
        logic [FIELD_BITS-1:0] tid;
    } t_in_item;

    typedef struct packed {
        logic                  emit;
        logic                  from;
        logic                  next_src;
        logic                  done;
        logic [FIELD_BITS-1:0] key;
        logic [FIELD_BITS-1:0] val;
        logic [FIELD_BITS-1:0] tid;
    } t_result;

endpackage

### rtl/core/two_way_sorted_merge_dedup.sv
// Merges two key-sorted streams (A newer, B older) into one sorted stream,
// one head entry held per stream. Each accepted input item yields exactly one
// output item through the input and merge registers; one item per cycle is
// sustained while downstream keeps m_axis_tready high. The rate is set by the
// single head compare (key order, equality, transaction order) in the merge
// stage; the visibility check against visible_limit runs one stage earlier.
// Output tuser carries emit_valid, out_from and next_source; tlast carries
// all_done. Key and value fields are zero fill above KEY_BITS and VALUE_BITS.
module two_way_sorted_merge_dedup #(
    parameter int KEY_BITS   = tsmd_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = tsmd_pkg::DEF_VALUE_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [tsmd_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [tsmd_pkg::FIELD_BITS-1:0]       i_cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // entry_key, entry_value, entry_tranc
    input  logic [tsmd_pkg::DATA_BITS-1:0]        s_axis_tdata,
    // source
    input  logic                                  s_axis_tuser,
    input  logic                                  s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // out_key, out_value, out_tranc
    output logic [tsmd_pkg::DATA_BITS-1:0]        m_axis_tdata,
    // emit_valid, out_from, next_source
    output logic [tsmd_pkg::OUT_USER_BITS-1:0]    m_axis_tuser,
    output logic                                  m_axis_tlast
);
    import tsmd_pkg::*;

    logic     w_advance;
    logic     w_item_valid;
    logic     w_keep;
    t_in_item w_item;
    t_result  w_res;

    tsmd_in_stage u_in_stage (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .s_axis_tlast    (s_axis_tlast),
        .i_advance       (w_advance),
        .o_item_valid    (w_item_valid),
        .o_item          (w_item),
        .o_keep_versions (w_keep)
    );

    tsmd_merge_core #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_merge_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (w_item_valid),
        .i_item          (w_item),
        .i_keep_versions (w_keep),
        .i_out_ready     (m_axis_tready),
        .o_advance       (w_advance),
        .o_out_valid     (m_axis_tvalid),
        .o_result        (w_res)
    );

    assign m_axis_tdata = {w_res.tid, w_res.val, w_res.key};
    assign m_axis_tuser = {w_res.next_src, w_res.from, w_res.emit};
    assign m_axis_tlast = w_res.done;

endmodule

### rtl/core/tsmd_in_stage.sv
module tsmd_in_stage (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [tsmd_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [tsmd_pkg::FIELD_BITS-1:0]      i_cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [tsmd_pkg::DATA_BITS-1:0]       s_axis_tdata,
    input  logic                                 s_axis_tuser,
    input  logic                                 s_axis_tlast,
    input  logic                                 i_advance,
    output logic                                 o_item_valid,
    output tsmd_pkg::t_in_item                   o_item,
    output logic                                 o_keep_versions
);
    import tsmd_pkg::*;

    logic [FIELD_BITS-1:0] r_limit;
    logic                  r_keep;
    logic                  r_in_valid;
    logic                  n_in_valid;
    t_in_item              r_item;
    t_in_item              n_item;
    logic                  w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
            r_keep  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VISIBLE_LIMIT: r_limit <= i_cfg_data;
                CFG_KEEP_VERSIONS: r_keep  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !r_in_valid || i_advance;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_item.src  = s_axis_tuser;
        n_item.last = s_axis_tlast;
        n_item.key  = s_axis_tdata[FIELD_BITS-1:0];
        n_item.val  = s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS];
        n_item.tid  = s_axis_tdata[3*FIELD_BITS-1:2*FIELD_BITS];
        // visibility settled here; merge compares only keys and tids
        n_item.vis  = (r_limit == '0) || (n_item.tid <= r_limit);

        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (i_advance) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

    assign o_item_valid    = r_in_valid;
    assign o_item          = r_item;
    assign o_keep_versions = r_keep;

endmodule

### rtl/core/tsmd_merge_core.sv
module tsmd_merge_core #(
    parameter int KEY_BITS   = tsmd_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = tsmd_pkg::DEF_VALUE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_item_valid,
    input  tsmd_pkg::t_in_item   i_item,
    input  logic                 i_keep_versions,
    input  logic                 i_out_ready,
    output logic                 o_advance,
    output logic                 o_out_valid,
    output tsmd_pkg::t_result    o_result
);
    import tsmd_pkg::*;

    logic                  r_a_full, r_a_over, r_b_full, r_b_over;
    logic [KEY_BITS-1:0]   r_a_key, r_b_key;
    logic [VALUE_BITS-1:0] r_a_val, r_b_val;
    logic [FIELD_BITS-1:0] r_a_tid, r_b_tid;

    logic                  n_a_full, n_a_over, n_b_full, n_b_over;
    logic [KEY_BITS-1:0]   n_a_key, n_b_key;
    logic [VALUE_BITS-1:0] n_a_val, n_b_val;
    logic [FIELD_BITS-1:0] n_a_tid, n_b_tid;

    logic                  r_out_valid;
    logic                  n_out_valid;
    t_result               r_res;
    t_result               n_res;

    logic                  w_step;
    logic                  w_load;
    logic                  w_take_a;
    logic                  w_take_b;
    logic                  w_key_eq;

    assign o_advance = !r_out_valid || i_out_ready;
    assign w_step    = i_item_valid && o_advance;

    always_comb begin
        n_a_full = r_a_full;
        n_a_over = r_a_over;
        n_a_key  = r_a_key;
        n_a_val  = r_a_val;
        n_a_tid  = r_a_tid;
        n_b_full = r_b_full;
        n_b_over = r_b_over;
        n_b_key  = r_b_key;
        n_b_val  = r_b_val;
        n_b_tid  = r_b_tid;
        w_take_a = 1'b0;
        w_take_b = 1'b0;

        // take the item into its head slot
        if (i_item.src == SRC_A) begin
            w_load = !i_item.last && !r_a_over && !r_a_full && i_item.vis;
            if (i_item.last) begin
                n_a_over = 1'b1;
            end
            if (w_load) begin
                n_a_full = 1'b1;
                n_a_key  = i_item.key[KEY_BITS-1:0];
                n_a_val  = i_item.val[VALUE_BITS-1:0];
                n_a_tid  = i_item.tid;
            end
        end else begin
            w_load = !i_item.last && !r_b_over && !r_b_full && i_item.vis;
            if (i_item.last) begin
                n_b_over = 1'b1;
            end
            if (w_load) begin
                n_b_full = 1'b1;
                n_b_key  = i_item.key[KEY_BITS-1:0];
                n_b_val  = i_item.val[VALUE_BITS-1:0];
                n_b_tid  = i_item.tid;
            end
        end

        w_key_eq = (n_a_key == n_b_key);

        // drop the older duplicate from B
        if (!i_keep_versions && n_a_full && n_b_full && w_key_eq) begin
            n_b_full = 1'b0;
        end

        if (n_a_full && n_b_full) begin
            if (!w_key_eq) begin
                w_take_a = (n_a_key < n_b_key);
            end else begin
                w_take_a = (n_a_tid > n_b_tid);
            end
            w_take_b = !w_take_a;
        end else if (n_a_full && n_b_over) begin
            w_take_a = 1'b1;
        end else if (n_b_full && n_a_over) begin
            w_take_b = 1'b1;
        end

        n_res.emit = w_take_a || w_take_b;
        n_res.from = w_take_b;
        n_res.key  = '0;
        n_res.val  = '0;
        n_res.tid  = '0;
        if (w_take_a) begin
            n_res.key = FIELD_BITS'(n_a_key);
            n_res.val = FIELD_BITS'(n_a_val);
            n_res.tid = n_a_tid;
            n_a_full  = 1'b0;
        end else if (w_take_b) begin
            n_res.key = FIELD_BITS'(n_b_key);
            n_res.val = FIELD_BITS'(n_b_val);
            n_res.tid = n_b_tid;
            n_b_full  = 1'b0;
        end

        // A first when both slots want an item
        if (!n_a_full && !n_a_over) begin
            n_res.next_src = SRC_A;
        end else if (!n_b_full && !n_b_over) begin
            n_res.next_src = SRC_B;
        end else begin
            n_res.next_src = SRC_A;
        end
        n_res.done = n_a_over && n_b_over && !n_a_full && !n_b_full;

        if (w_step) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_full    <= 1'b0;
            r_a_over    <= 1'b0;
            r_b_full    <= 1'b0;
            r_b_over    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_step) begin
                r_a_full <= n_a_full;
                r_a_over <= n_a_over;
                r_b_full <= n_b_full;
                r_b_over <= n_b_over;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_a_key <= n_a_key;
            r_a_val <= n_a_val;
            r_a_tid <= n_a_tid;
            r_b_key <= n_b_key;
            r_b_val <= n_b_val;
            r_b_tid <= n_b_tid;
            r_res   <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_res;

endmodule
